>>> rtl/cte_pkg.sv
`default_nettype none

package cte_pkg;

   // field widths
   localparam int IN_W  = 16;
   localparam int ANG_W = 17;
   localparam int CFG_W = 16;
   localparam int SAT_W = 20;

   // angle limits in 1/256 degree
   localparam logic signed [ANG_W-1:0] ANG_POS = 17'sd46080;
   localparam logic signed [ANG_W-1:0] ANG_NEG = -17'sd46080;

   // cordic datapath
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_IDX_W       = 5;
   localparam int ATAN_W           = 22;
   localparam int CX_W             = 19;
   localparam int Z_W              = 26;
   localparam logic signed [Z_W-1:0] Z_HALF_TURN = 26'sd11796480;
   localparam logic signed [Z_W-1:0] Z_RND       = 26'sd128;

   // serial multiplier
   localparam int MCAND_W = 18;
   localparam int MULT_W  = 16;
   localparam int PROD_W  = 19;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_LIMIT   = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] GYRO_GAIN_RST    = 16'd639;
   localparam logic [CFG_W-1:0] BLEND_WEIGHT_RST = 16'd58982;
   localparam logic [CFG_W-1:0] TILT_LIMIT_RST   = 16'd11520;

   typedef struct packed {
      logic                    done;
      logic signed [ANG_W-1:0] angle;
   } cordic_res_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] value;
   } mult_res_type;

   // arctangent of 2^-i in degree * 2^16, rounded
   function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] r;
      case (idx)
         5'd0:    r = 22'd2949120;
         5'd1:    r = 22'd1740967;
         5'd2:    r = 22'd919879;
         5'd3:    r = 22'd466945;
         5'd4:    r = 22'd234379;
         5'd5:    r = 22'd117304;
         5'd6:    r = 22'd58666;
         5'd7:    r = 22'd29335;
         5'd8:    r = 22'd14668;
         5'd9:    r = 22'd7334;
         5'd10:   r = 22'd3667;
         5'd11:   r = 22'd1833;
         5'd12:   r = 22'd917;
         5'd13:   r = 22'd458;
         5'd14:   r = 22'd229;
         5'd15:   r = 22'd115;
         5'd16:   r = 22'd57;
         5'd17:   r = 22'd29;
         5'd18:   r = 22'd14;
         5'd19:   r = 22'd7;
         5'd20:   r = 22'd4;
         5'd21:   r = 22'd2;
         5'd22:   r = 22'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // clamp to +/-180 degrees
   function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [SAT_W-1:0] v);
      logic signed [ANG_W-1:0] r;
      if (v > SAT_W'(ANG_POS)) begin
         r = ANG_POS;
      end else if (v < SAT_W'(ANG_NEG)) begin
         r = ANG_NEG;
      end else begin
         r = v[ANG_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cte_cordic.sv
`default_nettype none

module cte_cordic
   import cte_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [IN_W-1:0] vec_x,
   input  wire logic signed [IN_W-1:0] vec_y,
   output cordic_res_type              res
);

   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic                    zero_ff;
   logic [CNT_W-1:0]        iter_ff;
   logic signed [CX_W-1:0]  cx_ff;
   logic signed [CX_W-1:0]  cy_ff;
   logic signed [Z_W-1:0]   z_ff;

   logic signed [CX_W-1:0]  cx0;
   logic signed [CX_W-1:0]  cy0;
   logic signed [CX_W-1:0]  dx;
   logic signed [CX_W-1:0]  dy;
   logic signed [Z_W-1:0]   step_ang;
   logic signed [Z_W-1:0]   z_rnd;
   logic signed [Z_W-9:0]   z_deg;

   // start vector and per-step shifted terms
   always_comb begin
      cx0      = CX_W'(vec_x);
      cy0      = CX_W'(vec_y);
      dx       = cy_ff >>> iter_ff;
      dy       = cx_ff >>> iter_ff;
      step_ang = {{(Z_W-ATAN_W){1'b0}}, atan_lut(ATAN_IDX_W'(iter_ff))};
   end

   // control: one micro-rotation per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else if (busy_ff) begin
         iter_ff <= iter_ff + 1'b1;
         done_ff <= (iter_ff == LAST);
         if (iter_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // vector and angle datapath
   always_ff @(posedge clock) begin
      if (start) begin
         zero_ff <= (vec_x == '0) && (vec_y == '0);
         if (vec_x[IN_W-1]) begin
            cx_ff <= -cx0;
            cy_ff <= -cy0;
            z_ff  <= vec_y[IN_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
         end else begin
            cx_ff <= cx0;
            cy_ff <= cy0;
            z_ff  <= '0;
         end
      end else if (busy_ff) begin
         if (!cy_ff[CX_W-1]) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            z_ff  <= z_ff + step_ang;
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            z_ff  <= z_ff - step_ang;
         end
      end
   end

   // round to 1/256 degree and clamp; a zero vector gives 0
   always_comb begin
      z_rnd     = z_ff + Z_RND;
      z_deg     = z_rnd[Z_W-1:8];
      res.done  = done_ff;
      res.angle = zero_ff ? '0 : sat_angle(SAT_W'(z_deg));
   end

endmodule

`default_nettype wire

>>> rtl/cte_mult.sv
`default_nettype none

module cte_mult
   import cte_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [MCAND_W-1:0] mcand,
   input  wire logic [MULT_W-1:0]         mplier,
   output mult_res_type                   res
);

   localparam int CNT_W = $clog2(MULT_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(MULT_W - 1);

   logic                      busy_ff;
   logic                      done_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [MCAND_W-1:0] mcand_ff;
   logic signed [PROD_W-1:0]  hi_ff;
   logic [MULT_W-1:0]         lo_ff;

   logic signed [PROD_W-1:0]  addend;
   logic signed [PROD_W-1:0]  sum;

   // one multiplier bit per cycle, product shifts right
   always_comb begin
      addend = lo_ff[0] ? PROD_W'(mcand_ff) : '0;
      sum    = hi_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + 1'b1;
         done_ff <= (cnt_ff == LAST);
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         hi_ff    <= '0;
         lo_ff    <= mplier;
      end else if (busy_ff) begin
         hi_ff <= {sum[PROD_W-1], sum[PROD_W-1:1]};
         lo_ff <= {sum[0], lo_ff[MULT_W-1:1]};
      end
   end

   // product / 2^16 rounded half up
   always_comb begin
      res.done  = done_ff;
      res.value = hi_ff + PROD_W'(lo_ff[MULT_W-1]);
   end

endmodule

`default_nettype wire

>>> rtl/complementary_tilt_estimator_unit.sv
// Flow: an accepted req starts the iterative CORDIC and the first pass of the bit-serial
//   16-bit multiplier (gyro gain) together; once both are done, a second multiplier pass
//   (blend weight) runs, then the result goes to the output register; the seeding
//   transaction skips the blend pass.
// Occupancy: one transaction in work at a time; the output register frees the core.
// Reset: synchronous, active high; filters, fused angle, seed flag clear, csr defaults load.
`default_nettype none

module complementary_tilt_estimator_unit
   import cte_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [IN_W-1:0]  req_accel_x,
   input  wire logic signed [IN_W-1:0]  req_accel_z,
   input  wire logic signed [IN_W-1:0]  req_gyro_y,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [ANG_W-1:0]      rsp_tilt_angle,
   output logic signed [ANG_W-1:0]      rsp_accel_tilt,
   output logic                         rsp_tilt_fault,
   output logic                         rsp_first_sample,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CFG_W-1:0]        csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_BMUL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]              state_ff;
   logic [1:0]              state_in;

   logic [CFG_W-1:0]        gain_ff;
   logic [CFG_W-1:0]        weight_ff;
   logic [CFG_W-1:0]        limit_ff;

   logic signed [IN_W-1:0]  filt_x_ff;
   logic signed [IN_W-1:0]  filt_z_ff;
   logic signed [IN_W-1:0]  filt_x_in;
   logic signed [IN_W-1:0]  filt_z_in;
   logic signed [ANG_W-1:0] fused_ff;
   logic                    seeded_ff;

   logic                    cdone_ff;
   logic                    gdone_ff;
   logic signed [ANG_W-1:0] acc_ff;
   logic signed [ANG_W-1:0] inc_ff;
   logic signed [ANG_W-1:0] res_ff;

   logic                    rsp_valid_ff;
   logic signed [ANG_W-1:0] rsp_angle_ff;
   logic signed [ANG_W-1:0] rsp_acc_ff;
   logic                    rsp_fault_ff;
   logic                    rsp_first_ff;

   logic                    accept;
   logic                    blend_start;
   logic                    out_free;
   logic [IN_W:0]           sum_x;
   logic [IN_W:0]           sum_z;
   logic signed [PROD_W-1:0] diff;
   logic signed [SAT_W-1:0]  blend_sum;
   logic [ANG_W-1:0]         mag;
   logic                     fault;

   logic                      mult_start;
   logic signed [MCAND_W-1:0] mult_mcand;
   logic [MULT_W-1:0]         mult_mplier;
   cordic_res_type            cordic_res;
   mult_res_type              mult_res;

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tilt_angle   = rsp_angle_ff;
   assign rsp_accel_tilt   = rsp_acc_ff;
   assign rsp_tilt_fault   = rsp_fault_ff;
   assign rsp_first_sample = rsp_first_ff;

   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign blend_start = (state_ff == ST_RUN) && cdone_ff && gdone_ff && seeded_ff;

   // accel averaging with previous filtered value
   always_comb begin
      sum_x     = {req_accel_x[IN_W-1], req_accel_x} + {filt_x_ff[IN_W-1], filt_x_ff};
      sum_z     = {req_accel_z[IN_W-1], req_accel_z} + {filt_z_ff[IN_W-1], filt_z_ff};
      filt_x_in = sum_x[IN_W:1];
      filt_z_in = sum_z[IN_W:1];
   end

   // shared multiplier: gyro gain at accept, blend weight later
   always_comb begin
      diff        = PROD_W'(fused_ff) + PROD_W'(inc_ff) - PROD_W'(acc_ff);
      mult_start  = accept || blend_start;
      mult_mcand  = accept ? MCAND_W'(req_gyro_y) : diff[MCAND_W-1:0];
      mult_mplier = accept ? gain_ff : weight_ff;
      blend_sum   = SAT_W'(mult_res.value) + SAT_W'(acc_ff);
   end

   cte_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .vec_x (filt_z_in),
      .vec_y (filt_x_in),
      .res   (cordic_res)
   );

   cte_mult u_mult (
      .clock  (clock),
      .reset  (reset),
      .start  (mult_start),
      .mcand  (mult_mcand),
      .mplier (mult_mplier),
      .res    (mult_res)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cdone_ff && gdone_ff) state_in = seeded_ff ? ST_BMUL : ST_DONE;
         end
         ST_BMUL: begin
            if (mult_res.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fault on the fused angle magnitude, never on the seeding transaction
   always_comb begin
      mag   = res_ff[ANG_W-1] ? ANG_W'(-res_ff) : ANG_W'(res_ff);
      fault = seeded_ff && (mag > {1'b0, limit_ff});
   end

   // control state, filter state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         gain_ff   <= GYRO_GAIN_RST;
         weight_ff <= BLEND_WEIGHT_RST;
         limit_ff  <= TILT_LIMIT_RST;
         filt_x_ff <= '0;
         filt_z_ff <= '0;
         fused_ff  <= '0;
         seeded_ff <= 1'b0;
         cdone_ff  <= 1'b0;
         gdone_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GYRO_GAIN:    gain_ff   <= csr_data;
               CSR_BLEND_WEIGHT: weight_ff <= csr_data;
               CSR_TILT_LIMIT:   limit_ff  <= csr_data;
               default: ;
            endcase
         end

         if (accept) begin
            filt_x_ff <= filt_x_in;
            filt_z_ff <= filt_z_in;
            cdone_ff  <= 1'b0;
            gdone_ff  <= 1'b0;
         end else if (state_ff == ST_RUN) begin
            if (cordic_res.done) cdone_ff <= 1'b1;
            if (mult_res.done)   gdone_ff <= 1'b1;
         end

         if (state_ff == ST_DONE && out_free) begin
            fused_ff     <= res_ff;
            seeded_ff    <= 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath captures
   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN) begin
         if (cordic_res.done) acc_ff <= cordic_res.angle;
         if (mult_res.done)   inc_ff <= mult_res.value[ANG_W-1:0];
         if (cdone_ff && gdone_ff && !seeded_ff) res_ff <= acc_ff;
      end
      if (state_ff == ST_BMUL && mult_res.done) begin
         res_ff <= sat_angle(blend_sum);
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_angle_ff <= res_ff;
         rsp_acc_ff   <= acc_ff;
         rsp_fault_ff <= fault;
         rsp_first_ff <= !seeded_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cte_checker.sv
`default_nettype none

module cte_checker
   import cte_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [ANG_W-1:0] rsp_tilt_angle,
   input wire logic signed [ANG_W-1:0] rsp_accel_tilt,
   input wire logic                    rsp_tilt_fault,
   input wire logic                    rsp_first_sample
);

   // a pending result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transaction completed");

   // one transaction in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted transaction");

   // both angles stay within +/-180 degrees
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tilt_angle <= ANG_POS) && (rsp_tilt_angle >= ANG_NEG)
                 && (rsp_accel_tilt <= ANG_POS) && (rsp_accel_tilt >= ANG_NEG))
      else $error("angle out of range");

   // seeding result copies the accel tilt and never faults
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_sample |-> !rsp_tilt_fault && (rsp_tilt_angle == rsp_accel_tilt))
      else $error("seeding result inconsistent");

endmodule

bind complementary_tilt_estimator_unit cte_checker u_cte_checker (.*);

`default_nettype wire

>>> tb/tb_complementary_tilt_estimator_unit.sv
module tb_complementary_tilt_estimator_unit;
   import cte_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASES            = 6;
   localparam int SAMPLES_PER_PHASE = 230;
   localparam int HOLD_AT           = 1050;
   localparam int HOLD_CYCLES       = 200;
   localparam int END_CYCLES        = 64;
   localparam int CYCLE_LIMIT       = 400000;

   typedef struct packed {
      logic signed [IN_W-1:0] accel_x;
      logic signed [IN_W-1:0] accel_z;
      logic signed [IN_W-1:0] gyro_y;
   } imu_sample_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] tilt_angle;
      logic signed [ANG_W-1:0] accel_tilt;
      logic                    tilt_fault;
      logic                    first_sample;
   } tilt_result_type;

   // block ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [IN_W-1:0]  req_accel_x = '0;
   logic signed [IN_W-1:0]  req_accel_z = '0;
   logic signed [IN_W-1:0]  req_gyro_y = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [ANG_W-1:0] rsp_tilt_angle;
   logic signed [ANG_W-1:0] rsp_accel_tilt;
   logic                    rsp_tilt_fault;
   logic                    rsp_first_sample;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]        csr_data = '0;

   // predictor state and register copies
   int          filt_x = 0;
   int          filt_z = 0;
   int          fused = 0;
   logic        seeded = 1'b0;
   logic [CFG_W-1:0] gyro_gain = GYRO_GAIN_RST;
   logic [CFG_W-1:0] blend_weight = BLEND_WEIGHT_RST;
   logic [CFG_W-1:0] tilt_limit = TILT_LIMIT_RST;

   // arctangent of 2^-i in degree * 2^16
   int atan_deg16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   imu_sample_type  pending_samples[$];
   tilt_result_type expected_tilts[$];

   logic req_fire = 1'b0;
   int   samples_taken = 0;
   int   error_count = 0;
   int   cycle_count = 0;
   int   send_idle_pct = 28;
   int   recv_idle_pct = 49;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   int   base_x = 0;
   int   base_z = 16384;

   complementary_tilt_estimator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_accel_x      (req_accel_x),
      .req_accel_z      (req_accel_z),
      .req_gyro_y       (req_gyro_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tilt_angle   (rsp_tilt_angle),
      .rsp_accel_tilt   (rsp_accel_tilt),
      .rsp_tilt_fault   (rsp_tilt_fault),
      .rsp_first_sample (rsp_first_sample),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   // clamp to +/-180 degrees
   function automatic longint clamp_angle(input longint v);
      if (v > longint'(ANG_POS)) return longint'(ANG_POS);
      if (v < longint'(ANG_NEG)) return longint'(ANG_NEG);
      return v;
   endfunction

   // vectoring cordic, atan2(y, x) in 1/256 degree
   function automatic int accel_atan2(input int y, input int x);
      longint cx, cy, z, dx, dy;
      cx = x;
      cy = y;
      z  = 0;
      if (x == 0 && y == 0) return 0;
      // left half plane: mirror and start from +/-180 degrees
      if (cx < 0) begin
         z  = (cy >= 0) ? 64'sd11796480 : -64'sd11796480;
         cx = -cx;
         cy = -cy;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            z  += atan_deg16[i];
         end else begin
            cx -= dx;
            cy += dy;
            z  -= atan_deg16[i];
         end
      end
      return int'(clamp_angle((z + 128) >>> 8));
   endfunction

   // filter, seed or integrate and blend one sample
   function automatic tilt_result_type predict_tilt(input imu_sample_type s);
      tilt_result_type r;
      longint step, w, mix, mag;
      int acc;
      filt_x = (int'(s.accel_x) + filt_x) >>> 1;
      filt_z = (int'(s.accel_z) + filt_z) >>> 1;
      acc = accel_atan2(filt_x, filt_z);
      if (!seeded) begin
         seeded = 1'b1;
         fused = acc;
         r.tilt_fault = 1'b0;
         r.first_sample = 1'b1;
      end else begin
         step  = (longint'(s.gyro_y) * longint'(gyro_gain) + 32768) >>> 16;
         w     = longint'(blend_weight);
         mix   = w * (longint'(fused) + step) + (65536 - w) * longint'(acc);
         fused = int'(clamp_angle((mix + 32768) >>> 16));
         mag   = (fused < 0) ? -longint'(fused) : longint'(fused);
         r.tilt_fault = (mag > longint'(tilt_limit));
         r.first_sample = 1'b0;
      end
      r.tilt_angle = ANG_W'(fused);
      r.accel_tilt = ANG_W'(acc);
      return r;
   endfunction

   function automatic int rand_between(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic logic signed [IN_W-1:0] edge_value();
      case ($urandom_range(5))
         0: return -16'sd32768;
         1: return -16'sd1;
         2: return 16'sd0;
         3: return 16'sd1;
         4: return 16'sd32767;
         default: return IN_W'($urandom);
      endcase
   endfunction

   // a slowly tilting body with noise in 45 of 100 picks, else wild, tiny or edge samples
   function automatic imu_sample_type random_sample();
      imu_sample_type s;
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if ($urandom_range(15) == 0) begin
            base_x = rand_between(-20000, 20000);
            base_z = rand_between(-20000, 20000);
         end
         s.accel_x = IN_W'(base_x + rand_between(-256, 256));
         s.accel_z = IN_W'(base_z + rand_between(-256, 256));
         s.gyro_y  = IN_W'(rand_between(-3000, 3000));
      end else if (pick < 72) begin
         s.accel_x = IN_W'($urandom);
         s.accel_z = IN_W'($urandom);
         s.gyro_y  = IN_W'($urandom);
      end else if (pick < 86) begin
         s.accel_x = IN_W'(rand_between(-4, 4));
         s.accel_z = IN_W'(rand_between(-4, 4));
         s.gyro_y  = IN_W'(rand_between(-4, 4));
      end else begin
         s.accel_x = edge_value();
         s.accel_z = edge_value();
         s.gyro_y  = edge_value();
      end
      return s;
   endfunction

   function automatic void queue_sample(input int ax, input int az, input int gy);
      imu_sample_type s;
      s.accel_x = IN_W'(ax);
      s.accel_z = IN_W'(az);
      s.gyro_y  = IN_W'(gy);
      pending_samples.push_back(s);
   endfunction

   task automatic check_field(input string field, input logic signed [ANG_W-1:0] want,
                              input logic signed [ANG_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // register write transaction
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] weight,
                                 input logic [CFG_W-1:0] limit);
      write_register(CSR_GYRO_GAIN, gain);
      write_register(CSR_BLEND_WEIGHT, weight);
      write_register(CSR_TILT_LIMIT, limit);
   endtask

   // sender holds off until every sample is taken and answered
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_tilts.size() != 0)
         @(posedge clock);
   endtask

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_accel_x <= pending_samples[0].accel_x;
            req_accel_z <= pending_samples[0].accel_z;
            req_gyro_y  <= pending_samples[0].gyro_y;
            void'(pending_samples.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with one long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && samples_taken >= HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: register copies, prediction and result check
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GYRO_GAIN:    gyro_gain = csr_data;
               CSR_BLEND_WEIGHT: blend_weight = csr_data;
               CSR_TILT_LIMIT:   tilt_limit = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_tilts.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual angle %0d",
                        $time, rsp_tilt_angle);
               error_count++;
            end else begin
               check_field("tilt_angle", expected_tilts[0].tilt_angle, rsp_tilt_angle);
               check_field("accel_tilt", expected_tilts[0].accel_tilt, rsp_accel_tilt);
               check_field("tilt_fault", expected_tilts[0].tilt_fault, rsp_tilt_fault);
               check_field("first_sample", expected_tilts[0].first_sample, rsp_first_sample);
               void'(expected_tilts.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            expected_tilts.push_back(predict_tilt({req_accel_x, req_accel_z, req_gyro_y}));
            samples_taken++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: seeding on zero vector, field extremes, all quadrants
      queue_sample(0, 0, 0);
      queue_sample(0, 0, 32767);
      queue_sample(0, 0, -32768);
      queue_sample(32767, 32767, 0);
      queue_sample(32767, 32767, 32767);
      queue_sample(-32768, -32768, 0);
      queue_sample(-32768, -32768, -32768);
      queue_sample(32767, -32768, 1);
      queue_sample(32767, -32768, -1);
      queue_sample(-32768, 32767, 0);
      queue_sample(-32768, 32767, 100);
      queue_sample(0, -32768, 0);
      queue_sample(0, -32768, 0);
      queue_sample(0, 32767, 0);
      queue_sample(0, 32767, 0);
      queue_sample(32767, 0, 32767);
      queue_sample(32767, 0, 32767);
      queue_sample(-32768, 0, -32768);
      queue_sample(-32768, 0, -32768);
      queue_sample(-1, -1, -1);
      queue_sample(1, 1, 1);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         // writes to the unused index must not touch any register
         if (phase == 0 || phase == 3) write_register(CSR_UNUSED, CFG_W'($urandom));
         case (phase)
            0: apply_settings(GYRO_GAIN_RST, BLEND_WEIGHT_RST, TILT_LIMIT_RST);
            1: apply_settings(16'hFFFF, 16'hFFFF, 16'd0);
            2: apply_settings(16'd0, 16'd0, 16'hFFFF);
            3: apply_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
            4: apply_settings(16'd12000, 16'd62000, 16'd46080);
            default: apply_settings(CFG_W'($urandom), CFG_W'($urandom),
                                    CFG_W'($urandom_range(46080)));
         endcase
         if (phase < 2) begin
            send_idle_pct = 28;
            recv_idle_pct = 49;
         end else if (phase < 4) begin
            send_idle_pct = 49;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (SAMPLES_PER_PHASE) pending_samples.push_back(random_sample());
         wait_drained();
      end

      // let any stray result show up before the verdict
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
